>>> hw/rtl/iskl_pkg.sv
// Package: shared types, constants and key byte selection for the key lookup block.
`default_nettype none
package iskl_pkg;

  localparam int KEY_BYTES = 24;
  localparam int KEY_WORDS = 6;
  localparam int NUM_REGS = 7;
  localparam int ADDR_W = 5;

  localparam logic [7:0] CH_SEP = 8'h5C;
  localparam logic [7:0] CH_END = 8'h00;

  localparam logic [2:0] REG_KEY_LENGTH = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_NAME,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KEY_WORDS-1:0][31:0] key_words;
    logic [4:0]                 key_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    kind_t      kind;
    logic       done_res;
  } res_t;

  function automatic logic [7:0] key_byte(input logic [KEY_WORDS-1:0][31:0] words,
                                          input logic [4:0] idx);
    logic [31:0] w;
    w = words[idx[4:2]];
    return w[{idx[1:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/iskl_if.sv
// Channel interfaces: character input and result output, valid/ready handshake.
`default_nettype none
interface iskl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       start_req;

  modport source (output valid, output char_in, output start_req, input ready);
  modport sink (input valid, input char_in, input start_req, output ready);
endinterface

interface iskl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic [1:0] kind;
  logic       done_res;

  modport source (output valid, output value_byte, output kind, output done_res, input ready);
  modport sink (input valid, input value_byte, input kind, input done_res, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/iskl_cfg.sv
// APB register bank holding the searched key and its length.
`default_nettype none
module iskl_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [iskl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output iskl_pkg::cfg_t                  cfg
);

  logic [iskl_pkg::KEY_WORDS-1:0][31:0] key_words;
  logic [4:0]                           key_length;
  logic [2:0]                           reg_idx;
  logic                                 wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words  <= '0;
      key_length <= '0;
    end else if (wr_en) begin
      if (reg_idx < 3'(iskl_pkg::KEY_WORDS)) begin
        key_words[reg_idx] <= pwdata;
      end else if (reg_idx == iskl_pkg::REG_KEY_LENGTH) begin
        key_length <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < 3'(iskl_pkg::KEY_WORDS)) begin
      prdata = key_words[reg_idx];
    end else if (reg_idx == iskl_pkg::REG_KEY_LENGTH) begin
      prdata = {27'd0, key_length};
    end
  end

  assign cfg.key_words  = key_words;
  assign cfg.key_length = key_length;

endmodule
`default_nettype wire

>>> hw/rtl/infostring_key_lookup.sv
// Top level: backslash key/value string lookup with output register and skid stage.
`default_nettype none
// One character is taken per clock when the output side keeps up: each character needs
// one byte compare against the selected key byte and a counter update, done between the
// input handshake and the result register. A single-entry skid stage behind the result
// register lets the input keep flowing after the output stalls; the input stops only
// while the skid entry is full. Each value byte is registered. Found, not found and
// too long close the string, after which characters are dropped until the next
// start. Key words sit at byte addresses 0 to 20, the key length at 24.
module infostring_key_lookup #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  iskl_in_if.sink                         in_ch,
  iskl_out_if.source                      out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [iskl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  localparam int CW = $clog2(BUFFER_BYTES);
  localparam logic [CW-1:0] LIMIT = CW'(BUFFER_BYTES - 1);

  iskl_pkg::cfg_t   cfg;
  iskl_pkg::phase_t phase, phase_next;
  logic [CW-1:0]    char_count, char_count_next;
  logic             name_matches, name_matches_next;
  logic             name_overlong, name_overlong_next;

  iskl_pkg::res_t   res;
  logic             res_valid;
  iskl_pkg::res_t   out_data, skid_data;
  logic             out_valid, skid_valid;

  logic             accept;
  logic [7:0]       c;
  logic [CW-1:0]    klen;
  logic             byte_hit;
  logic             name_hit;
  iskl_pkg::phase_t cur;

  iskl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !skid_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_in;
  assign cur         = in_ch.start_req ? iskl_pkg::PH_FIRST : phase;
  assign klen        = CW'(cfg.key_length);
  assign byte_hit    = (char_count < klen) && (char_count < CW'(iskl_pkg::KEY_BYTES)) &&
                       (iskl_pkg::key_byte(cfg.key_words, char_count[4:0]) == c);
  assign name_hit    = name_overlong ? (cfg.key_length == 5'd0)
                                     : (name_matches && char_count == klen);

  // next state
  always_comb begin
    phase_next         = phase;
    char_count_next    = char_count;
    name_matches_next  = name_matches;
    name_overlong_next = name_overlong;
    if (accept) begin
      phase_next = cur;
      case (cur)
        iskl_pkg::PH_FIRST: begin
          if (c != iskl_pkg::CH_SEP) begin
            phase_next = iskl_pkg::PH_IDLE;
          end else begin
            phase_next         = iskl_pkg::PH_NAME;
            char_count_next    = '0;
            name_matches_next  = 1'b1;
            name_overlong_next = 1'b0;
          end
        end
        iskl_pkg::PH_NAME: begin
          if (c == iskl_pkg::CH_SEP) begin
            phase_next      = name_hit ? iskl_pkg::PH_VALUE : iskl_pkg::PH_SKIP;
            char_count_next = '0;
          end else if (c == iskl_pkg::CH_END) begin
            phase_next = iskl_pkg::PH_IDLE;
          end else if (!name_overlong) begin
            if (char_count >= LIMIT) begin
              name_overlong_next = 1'b1;
            end else begin
              if (!byte_hit) name_matches_next = 1'b0;
              char_count_next = char_count + CW'(1);
            end
          end
        end
        iskl_pkg::PH_VALUE: begin
          if (c == iskl_pkg::CH_END || c == iskl_pkg::CH_SEP || char_count >= LIMIT) begin
            phase_next = iskl_pkg::PH_IDLE;
          end else begin
            char_count_next = char_count + CW'(1);
          end
        end
        iskl_pkg::PH_SKIP: begin
          if (c == iskl_pkg::CH_END) begin
            phase_next = iskl_pkg::PH_IDLE;
          end else if (c == iskl_pkg::CH_SEP) begin
            phase_next         = iskl_pkg::PH_NAME;
            char_count_next    = '0;
            name_matches_next  = 1'b1;
            name_overlong_next = 1'b0;
          end
        end
        default: phase_next = cur;
      endcase
    end
  end

  // result of the accepted character
  always_comb begin
    res_valid      = 1'b0;
    res.value_byte = 8'd0;
    res.kind       = iskl_pkg::KIND_NONE;
    res.done_res   = 1'b1;
    if (accept) begin
      case (cur)
        iskl_pkg::PH_FIRST: res_valid = (c != iskl_pkg::CH_SEP);
        iskl_pkg::PH_NAME:  res_valid = (c == iskl_pkg::CH_END);
        iskl_pkg::PH_SKIP:  res_valid = (c == iskl_pkg::CH_END);
        iskl_pkg::PH_VALUE: begin
          res_valid = 1'b1;
          if (c == iskl_pkg::CH_END || c == iskl_pkg::CH_SEP) begin
            res.kind = iskl_pkg::KIND_FOUND;
          end else if (char_count >= LIMIT) begin
            res.kind = iskl_pkg::KIND_LONG;
          end else begin
            res.kind       = iskl_pkg::KIND_VALUE;
            res.value_byte = c;
            res.done_res   = 1'b0;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= iskl_pkg::PH_IDLE;
      char_count    <= '0;
      name_matches  <= 1'b1;
      name_overlong <= 1'b0;
    end else begin
      phase         <= phase_next;
      char_count    <= char_count_next;
      name_matches  <= name_matches_next;
      name_overlong <= name_overlong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ch.ready) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.value_byte = out_data.value_byte;
  assign out_ch.kind       = out_data.kind;
  assign out_ch.done_res   = out_data.done_res;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |=> phase == iskl_pkg::PH_IDLE)
    else $error("final result did not return to idle");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    char_count <= LIMIT)
    else $error("character count beyond buffer limit");

  a_value_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == iskl_pkg::KIND_VALUE |-> !out_data.done_res)
    else $error("value byte flagged as final");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for infostring_key_lookup: directed and random key/value strings checked by a predictor.
module tb;

  localparam int BUF_BYTES = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 90;

  class lookup_scoreboard;
    logic [31:0]      key_words [iskl_pkg::KEY_WORDS];
    logic [4:0]       key_len;
    iskl_pkg::phase_t ph;
    int unsigned      count;
    bit               name_ok;
    bit               name_long;
    iskl_pkg::res_t   expected_results [$];
    int               errors;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      key_len = '0;
      ph = iskl_pkg::PH_IDLE;
      count = 0;
      name_ok = 1'b1;
      name_long = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      if (idx == iskl_pkg::REG_KEY_LENGTH) key_len = v[4:0];
      else key_words[idx] = v;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function bit key_hit(int unsigned at, logic [7:0] c);
      if (at >= iskl_pkg::KEY_BYTES) return 1'b0;
      return key_words[at / 4][8 * (at % 4) +: 8] == c;
    endfunction

    function void open_name();
      ph = iskl_pkg::PH_NAME;
      count = 0;
      name_ok = 1'b1;
      name_long = 1'b0;
    endfunction

    function void emit(logic [7:0] b, iskl_pkg::kind_t k);
      iskl_pkg::res_t r;
      r.value_byte = b;
      r.kind = k;
      r.done_res = (k != iskl_pkg::KIND_VALUE);
      expected_results.push_back(r);
      if (r.done_res) ph = iskl_pkg::PH_IDLE;
    endfunction

    // predictor: one accepted transaction on the character channel
    function void note_char(logic [7:0] c, logic s);
      bit hit;
      if (s) ph = iskl_pkg::PH_FIRST;
      case (ph)
        iskl_pkg::PH_FIRST: begin
          if (c != iskl_pkg::CH_SEP) emit(8'h00, iskl_pkg::KIND_NONE);
          else open_name();
        end
        iskl_pkg::PH_NAME: begin
          if (c == iskl_pkg::CH_SEP) begin
            hit = name_long ? (key_len == 0) : (name_ok && count == key_len);
            ph = hit ? iskl_pkg::PH_VALUE : iskl_pkg::PH_SKIP;
            count = 0;
          end else if (c == iskl_pkg::CH_END) begin
            emit(8'h00, iskl_pkg::KIND_NONE);
          end else if (!name_long) begin
            if (count >= BUF_BYTES - 1) begin
              name_long = 1'b1;
            end else begin
              if (!(count < key_len && key_hit(count, c))) name_ok = 1'b0;
              count++;
            end
          end
        end
        iskl_pkg::PH_VALUE: begin
          if (c == iskl_pkg::CH_END || c == iskl_pkg::CH_SEP) begin
            emit(8'h00, iskl_pkg::KIND_FOUND);
          end else if (count >= BUF_BYTES - 1) begin
            emit(8'h00, iskl_pkg::KIND_LONG);
          end else begin
            count++;
            emit(c, iskl_pkg::KIND_VALUE);
          end
        end
        iskl_pkg::PH_SKIP: begin
          if (c == iskl_pkg::CH_END) emit(8'h00, iskl_pkg::KIND_NONE);
          else if (c == iskl_pkg::CH_SEP) open_name();
        end
        default: ;
      endcase
    endfunction

    function void check_result(iskl_pkg::res_t got);
      iskl_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h", got.kind, got.value_byte));
        return;
      end
      want = expected_results.pop_front();
      if (got.value_byte !== want.value_byte)
        report($sformatf("value_byte %02h, expected %02h", got.value_byte, want.value_byte));
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [iskl_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  iskl_in_if  in_ch ();
  iskl_out_if out_ch ();

  infostring_key_lookup #(.BUFFER_BYTES(BUF_BYTES)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lookup_scoreboard sb = new();

  logic [31:0]    key_w [iskl_pkg::KEY_WORDS];
  logic [4:0]     key_n;
  logic [7:0]     line_q [$];
  int unsigned    sent_items = 0;
  int unsigned    cycles = 0;
  bit             gaps_on = 1'b1;
  bit             hold_req = 1'b0;
  iskl_pkg::res_t out_seen;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_char(in_ch.char_in, in_ch.start_req);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      out_seen.value_byte = out_ch.value_byte;
      out_seen.kind = iskl_pkg::kind_t'(out_ch.kind);
      out_seen.done_res = out_ch.done_res;
      sb.check_result(out_seen);
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == iskl_pkg::CH_SEP);
    return c;
  endfunction

  function automatic logic [7:0] kbyte(int i);
    return key_w[i / 4][8 * (i % 4) +: 8];
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
  endtask

  task automatic load_key();
    for (int i = 0; i < iskl_pkg::KEY_WORDS; i++) reg_write(3'(i), key_w[i]);
    reg_write(iskl_pkg::REG_KEY_LENGTH, 32'(key_n));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_key_chars();
    for (int i = 0; i < iskl_pkg::KEY_BYTES; i++) key_w[i / 4][8 * (i % 4) +: 8] = rand_char();
  endtask

  task automatic send_item(input logic [7:0] c, input logic s);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.start_req <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i], i == 0);
    sent_items += line_q.size();
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_value(int n);
    repeat (n) line_q.push_back(rand_char());
  endtask

  // name variants: exact key, one byte off, one short or long, unrelated
  task automatic add_key_name(int mode);
    int n;
    int idx;
    logic [7:0] c;
    n = (key_n > iskl_pkg::KEY_BYTES) ? iskl_pkg::KEY_BYTES : int'(key_n);
    case (mode)
      0: begin
        for (int i = 0; i < n; i++) line_q.push_back(kbyte(i));
        if (key_n > iskl_pkg::KEY_BYTES) add_value($urandom_range(0, 2));
      end
      1: begin
        if (n == 0) begin
          line_q.push_back(rand_char());
        end else begin
          for (int i = 0; i < n; i++) line_q.push_back(kbyte(i));
          idx = line_q.size() - n + $urandom_range(0, n - 1);
          do c = rand_char(); while (c == line_q[idx]);
          line_q[idx] = c;
        end
      end
      2: begin
        if (n > 0 && $urandom_range(0, 1) == 0) begin
          for (int i = 0; i < n - 1; i++) line_q.push_back(kbyte(i));
        end else begin
          for (int i = 0; i < n; i++) line_q.push_back(kbyte(i));
          line_q.push_back(rand_char());
        end
      end
      default: add_value($urandom_range(0, 6));
    endcase
  endtask

  task automatic build_line();
    int nf;
    int m;
    int cut;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      line_q.push_back(rand_char());
      add_value($urandom_range(0, 3));
      line_q.push_back(iskl_pkg::CH_END);
      return;
    end
    line_q.push_back(iskl_pkg::CH_SEP);
    nf = $urandom_range(1, 4);
    for (int k = 0; k < nf; k++) begin
      m = $urandom_range(0, 4);
      add_key_name(m == 4 ? 0 : m);
      line_q.push_back(iskl_pkg::CH_SEP);
      add_value($urandom_range(0, 8));
      if (k < nf - 1) line_q.push_back(iskl_pkg::CH_SEP);
    end
    m = $urandom_range(0, 9);
    if (m <= 1) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
      if (m == 0) line_q.push_back(iskl_pkg::CH_END);
    end else begin
      line_q.push_back(iskl_pkg::CH_END);
    end
  endtask

  initial begin
    int unsigned target;
    bit paused;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= 8'h00;
    in_ch.start_req <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: key FF 01
    foreach (key_w[i]) key_w[i] = '0;
    key_w[0] = 32'h0000_01FF;
    key_n = 5'd2;
    load_key();
    line_q = '{8'h41, 8'hFF};
    send_line();
    line_q = '{iskl_pkg::CH_SEP, 8'hFF, 8'h01, iskl_pkg::CH_SEP, 8'h80, 8'h7F,
               iskl_pkg::CH_END};
    send_line();
    line_q = '{iskl_pkg::CH_SEP, 8'hFF, 8'h01, iskl_pkg::CH_SEP, iskl_pkg::CH_SEP};
    send_line();
    line_q = '{iskl_pkg::CH_SEP, 8'hFF, iskl_pkg::CH_SEP, 8'h01, iskl_pkg::CH_END};
    send_line();
    line_q = '{iskl_pkg::CH_SEP, 8'hFF};
    send_line();
    line_q = '{iskl_pkg::CH_SEP, 8'hFF, 8'h01, iskl_pkg::CH_SEP, 8'h01, iskl_pkg::CH_END};
    send_line();

    for (int p = 0; p < 7; p++) begin
      drain();
      repeat (10) @(posedge clk);
      case (p)
        0: begin
          foreach (key_w[i]) key_w[i] = '0;
          key_n = 5'd0;
        end
        1: begin
          fill_key_chars();
          key_n = 5'd24;
        end
        2: begin
          foreach (key_w[i]) key_w[i] = 32'hFFFF_FFFF;
          key_n = 5'd31;
        end
        3: begin
          fill_key_chars();
          key_n = 5'($urandom_range(1, 8));
        end
        4: begin
          fill_key_chars();
          key_n = 5'($urandom_range(1, 24));
          key_w[0][7:0] = key_w[0][7:0];
          begin
            int z;
            z = $urandom_range(0, key_n - 1);
            key_w[z / 4][8 * (z % 4) +: 8] = iskl_pkg::CH_END;
          end
        end
        5: begin
          foreach (key_w[i]) key_w[i] = $urandom();
          key_n = 5'($urandom_range(0, 24));
        end
        default: begin
          fill_key_chars();
          key_n = 5'($urandom_range(1, 6));
          gaps_on = 1'b0;
        end
      endcase
      load_key();
      if (p == 3) hold_req = 1'b1;

      if (p == 0) begin
        // overlong name counts as empty, matches the empty key
        line_q = '{iskl_pkg::CH_SEP};
        add_value(BUF_BYTES - 1 + $urandom_range(1, 5));
        line_q.push_back(iskl_pkg::CH_SEP);
        add_value(3);
        line_q.push_back(iskl_pkg::CH_END);
        send_line();
      end
      if (p == 1) begin
        line_q = '{iskl_pkg::CH_SEP};
        add_key_name(0);
        line_q.push_back(iskl_pkg::CH_SEP);
        add_value(BUF_BYTES - 1);
        line_q.push_back(iskl_pkg::CH_END);
        send_line();
        line_q = '{iskl_pkg::CH_SEP};
        add_key_name(0);
        line_q.push_back(iskl_pkg::CH_SEP);
        add_value(BUF_BYTES - 1 + $urandom_range(1, 4));
        line_q.push_back(iskl_pkg::CH_END);
        send_line();
        line_q = '{iskl_pkg::CH_SEP};
        add_value(BUF_BYTES + 1);
        line_q.push_back(iskl_pkg::CH_SEP);
        add_value(2);
        line_q.push_back(iskl_pkg::CH_SEP);
        add_key_name(0);
        line_q.push_back(iskl_pkg::CH_SEP);
        add_value(2);
        line_q.push_back(iskl_pkg::CH_END);
        send_line();
      end

      paused = 1'b0;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        build_line();
        send_line();
        if (p == 3 && !paused && sent_items + PHASE_ITEMS / 2 > target) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
